@@ src/tifr_pkg.sv @@
// shared codes, types and reply lookup for the telnet iac filter
package tifr_pkg;

  localparam logic [7:0] CODE_IAC  = 8'hFF;
  localparam logic [7:0] CODE_SE   = 8'hF0;
  localparam logic [7:0] CODE_SB   = 8'hFA;
  localparam logic [7:0] CODE_WILL = 8'hFB;
  localparam logic [7:0] CODE_WONT = 8'hFC;
  localparam logic [7:0] CODE_DO   = 8'hFD;
  localparam logic [7:0] CODE_DONT = 8'hFE;
  localparam logic [7:0] OPT_ECHO  = 8'h01;
  localparam logic [7:0] OPT_SGA   = 8'h03;

  // most words one input word can cause
  localparam int unsigned BURST_MAX = 3;

  typedef enum logic [2:0] {
    ST_DATA   = 3'd0,
    ST_IAC    = 3'd1,
    ST_OPTION = 3'd2,
    ST_SUB    = 3'd3,
    ST_SUBIAC = 3'd4
  } parse_state_t;

  typedef enum logic [1:0] {
    CMD_WILL = 2'd0,
    CMD_WONT = 2'd1,
    CMD_DO   = 2'd2,
    CMD_DONT = 2'd3
  } neg_cmd_t;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_RESP = 1'b1
  } res_kind_t;

  typedef struct packed {
    res_kind_t  kind;
    logic [7:0] value;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0]                  count;
    result_t [BURST_MAX-1:0]     res;
  } burst_t;

  function automatic logic [7:0] reply_for(neg_cmd_t cmd, logic [7:0] opt);
    logic [7:0] rep;
    case (cmd)
      CMD_WILL: rep = (opt == OPT_SGA) ? CODE_DO : CODE_DONT;
      CMD_WONT: rep = CODE_DONT;
      CMD_DO:   rep = (opt == OPT_ECHO || opt == OPT_SGA) ? CODE_WILL : CODE_WONT;
      CMD_DONT: rep = CODE_WONT;
      default:  rep = CODE_WONT;
    endcase
    return rep;
  endfunction

endpackage

@@ src/tifr_in_if.sv @@
// input channel: one received stream byte per word
interface tifr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

@@ src/tifr_out_if.sv @@
// result channel: filtered data or negotiation reply words
interface tifr_out_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_kind, output out_byte, output out_last,
                  input ready);
  modport sink   (input valid, input out_kind, input out_byte, input out_last,
                  output ready);
endinterface

@@ src/tifr_parser.sv @@
// telnet parse state machine and per-byte result burst decode
module tifr_parser
  import tifr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  output burst_t     burst
);

  parse_state_t state_r, state_nxt;
  neg_cmd_t     cmd_r, cmd_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    case (state_r)
      ST_IAC: begin
        if (in_byte == CODE_IAC) begin
          state_nxt = ST_DATA;
        end else if (in_byte >= CODE_WILL && in_byte <= CODE_DONT) begin
          cmd_nxt   = neg_cmd_t'(in_byte[1:0] - CODE_WILL[1:0]);
          state_nxt = ST_OPTION;
        end else if (in_byte == CODE_SB) begin
          state_nxt = ST_SUB;
        end else begin
          state_nxt = ST_DATA;
        end
      end
      ST_OPTION: begin
        cmd_nxt   = CMD_WILL;
        state_nxt = ST_DATA;
      end
      ST_SUB: begin
        if (in_byte == CODE_IAC) state_nxt = ST_SUBIAC;
      end
      ST_SUBIAC: begin
        if (in_byte == CODE_SE) begin
          state_nxt = ST_DATA;
        end else if (in_byte != CODE_IAC) begin
          state_nxt = ST_SUB;
        end
      end
      default: begin
        state_nxt = (in_byte == CODE_IAC) ? ST_IAC : ST_DATA;
      end
    endcase
  end

  // result burst for the current byte
  always_comb begin
    burst = '0;
    case (state_r)
      ST_IAC: begin
        if (in_byte == CODE_IAC) begin
          burst.count  = 2'd1;
          burst.res[0] = '{kind: KIND_DATA, value: CODE_IAC, last: 1'b1};
        end
      end
      ST_OPTION: begin
        burst.count  = 2'd3;
        burst.res[0] = '{kind: KIND_RESP, value: CODE_IAC, last: 1'b0};
        burst.res[1] = '{kind: KIND_RESP, value: reply_for(cmd_r, in_byte), last: 1'b0};
        burst.res[2] = '{kind: KIND_RESP, value: in_byte, last: 1'b1};
      end
      ST_SUB, ST_SUBIAC: begin
        burst.count = 2'd0;
      end
      default: begin
        if (in_byte != CODE_IAC) begin
          burst.count  = 2'd1;
          burst.res[0] = '{kind: KIND_DATA, value: in_byte, last: 1'b1};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_DATA;
      cmd_r   <= CMD_WILL;
    end else if (accept) begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

endmodule

@@ src/tifr_outq.sv @@
// result queue: takes up to three words a cycle, hands out one when popped
module tifr_outq
  import tifr_pkg::*;
#(
  parameter int unsigned DEPTH = 8
)(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  burst_t  burst,
  output logic    room,
  output logic    head_valid,
  output result_t head,
  input  logic    pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  result_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [PTR_W-1:0]   wr_idx [BURST_MAX];
  logic [PTR_W:0]     wr_sum [BURST_MAX];
  logic [PTR_W:0]     adv_sum;
  logic [1:0]         push_n;
  logic               pop_en;

  assign push_n     = push ? burst.count : 2'd0;
  assign head_valid = (count_r != '0);
  assign pop_en     = pop && head_valid;
  assign head       = mem_r[rd_ptr_r];
  assign room       = (count_r <= CNT_W'(DEPTH - BURST_MAX));

  // wrapped write slots for each word of the burst
  always_comb begin
    for (int i = 0; i < BURST_MAX; i++) begin
      wr_sum[i] = {1'b0, wr_ptr_r} + (PTR_W+1)'(i);
      wr_idx[i] = (wr_sum[i] >= (PTR_W+1)'(DEPTH)) ?
                  PTR_W'(wr_sum[i] - (PTR_W+1)'(DEPTH)) : wr_sum[i][PTR_W-1:0];
    end
  end

  always_comb begin
    adv_sum    = {1'b0, wr_ptr_r} + (PTR_W+1)'(push_n);
    wr_ptr_nxt = (adv_sum >= (PTR_W+1)'(DEPTH)) ?
                 PTR_W'(adv_sum - (PTR_W+1)'(DEPTH)) : adv_sum[PTR_W-1:0];
    rd_ptr_nxt = rd_ptr_r;
    if (pop_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    count_nxt = count_r + CNT_W'(push_n) - CNT_W'(pop_en);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < BURST_MAX; i++) begin
      if (push && (2'(i) < burst.count)) mem_r[wr_idx[i]] <= burst.res[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ src/telnet_iac_filter_responder.sv @@
// top level of the telnet iac filter and option responder
//
// in_ch carries one byte of the client stream per word; out_ch carries the
// results, each tagged as a filtered data byte or a negotiation reply byte,
// with out_last marking the final word caused by one input byte
// plain bytes pass straight through, iac iac gives a literal 0xff, an option
// command gives the three-word reply iac, reply, option, and subnegotiation
// is swallowed up to iac se
// a byte's result words are registered into the result queue when the byte is
// taken, and reach out_ch behind any words already waiting there
// throughput: one byte per cycle while there is room; the parser decodes
// each byte in a single pass and writes its whole burst into the result
// queue at once; the queue hands out one word a cycle and in_ch.ready stays
// high while it has room for a full three-word burst
// when the receiver stalls, words collect in the queue; once fewer than three
// slots are free in_ch.ready drops until out_ch.ready drains it
// reset (rst_n low, synchronous) empties the queue and puts the parser back
// in the data state with no pending command
module telnet_iac_filter_responder
  import tifr_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 8  // result queue slots, at least 3
)(
  input  logic         clk,
  input  logic         rst_n,
  tifr_in_if.sink      in_ch,
  tifr_out_if.source   out_ch
);

  burst_t  burst;     // words caused by the byte on in_ch
  logic    accept;    // input word taken this cycle
  logic    room;      // queue can absorb a full burst
  logic    head_valid;
  result_t head;

  assign in_ch.ready = room;
  assign accept      = in_ch.valid && room;

  // parse state and reply decode
  tifr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_ch.in_byte),
    .burst   (burst)
  );

  // result queue, decouples the stream side from the receiver
  tifr_outq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .burst      (burst),
    .room       (room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (out_ch.ready)
  );

  // queue head drives the result channel
  assign out_ch.valid    = head_valid;
  assign out_ch.out_kind = head.kind;
  assign out_ch.out_byte = head.value;
  assign out_ch.out_last = head.last;

endmodule

@@ src/tifr_checker.sv @@
// port level checks for the telnet iac filter, bound to the top level
module tifr_checker
  import tifr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic       out_last
);

  // a pending result word is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word withdrawn before it was taken");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result pending straight after reset");

  // a data word is always the only word of its input byte
  a_data_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_DATA) |-> out_last)
    else $error("data word without last flag");

  // with nothing queued the input side must be open
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while result queue empty");

endmodule

bind telnet_iac_filter_responder tifr_checker u_tifr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.out_kind),
  .out_last  (out_ch.out_last)
);
